@@ hdl/vsd_pkg.sv @@
// shared constants, register indexes and the equal-share table
// for the variance share decomposition block; no dependencies
package vsd_pkg;

  localparam int COEF_W      = 16;
  localparam int SQ_W        = 31;
  localparam int ACC_W       = 48;
  localparam int TOT_W       = 52;
  localparam int SHARE_W     = 16;
  localparam int IDX_W       = 3;
  localparam int HOR_W       = 8;
  localparam int NV_W        = 4;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 48;

  localparam int DEF_MAX_VARS    = 8;
  localparam int DEF_MAX_HORIZON = 256;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL = 8'd1;

  localparam logic [SHARE_W-1:0] ONE_Q15 = 16'd32768;

  // floor(32768 / n) for n of 1 to 15
  function automatic logic [SHARE_W-1:0] equal_share(input logic [NV_W-1:0] n);
    logic [SHARE_W-1:0] s;
    case (n)
      4'd1:    s = 16'd32768;
      4'd2:    s = 16'd16384;
      4'd3:    s = 16'd10922;
      4'd4:    s = 16'd8192;
      4'd5:    s = 16'd6553;
      4'd6:    s = 16'd5461;
      4'd7:    s = 16'd4681;
      4'd8:    s = 16'd4096;
      4'd9:    s = 16'd3640;
      4'd10:   s = 16'd3276;
      4'd11:   s = 16'd2978;
      4'd12:   s = 16'd2730;
      4'd13:   s = 16'd2520;
      4'd14:   s = 16'd2340;
      4'd15:   s = 16'd2184;
      default: s = 16'd32768;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/vsd_if.sv @@
// stream and configuration channel interfaces of the block
// depends on vsd_pkg for field widths
interface vsd_item_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vsd_pkg::COEF_W-1:0]    coefficient;
  logic                                 restart;
  modport source (output valid, coefficient, restart, input ready);
  modport sink   (input valid, coefficient, restart, output ready);
endinterface

interface vsd_result_if;
  logic                            valid;
  logic                            ready;
  logic [vsd_pkg::SHARE_W-1:0]     share;
  logic [vsd_pkg::IDX_W-1:0]       variable_index;
  logic [vsd_pkg::IDX_W-1:0]       shock_index;
  logic [vsd_pkg::HOR_W-1:0]       horizon_index;
  logic                            row_last;
  modport source (output valid, share, variable_index, shock_index, horizon_index,
                  row_last, input ready);
  modport sink   (input valid, share, variable_index, shock_index, horizon_index,
                  row_last, output ready);
endinterface

interface vsd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [vsd_pkg::CFG_IDX_W-1:0]     index;
  logic [vsd_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/vsd_store.sv @@
// accumulator memory with one valid bit per entry; unwritten entries read zero
// depends on vsd_pkg
module vsd_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clr,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [vsd_pkg::ACC_W-1:0]  wdata,
  input  logic [AW-1:0]              raddr,
  output logic [vsd_pkg::ACC_W-1:0]  rdata
);
  import vsd_pkg::*;

  logic [ACC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [ACC_W-1:0] rd_raw;
  logic             rd_vld;

  // valid bits, cleared at once by reset or restart
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_raw <= mem[raddr];
    rd_vld <= valid[raddr] & ~clr & ~rst;
  end

  assign rdata = rd_vld ? rd_raw : '0;

endmodule

@@ hdl/vsd_divider.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// computes floor(dividend * 2^15 / divisor) for dividend <= divisor; uses vsd_pkg
module vsd_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [vsd_pkg::ACC_W-1:0]    dividend,
  input  logic [vsd_pkg::TOT_W-1:0]    divisor,
  output logic                         done,
  output logic [vsd_pkg::SHARE_W-1:0]  quotient
);
  import vsd_pkg::*;

  localparam int RW = TOT_W + 1;
  localparam logic [4:0] LAST_STEP = 5'(SHARE_W - 1);

  logic            busy;
  logic [4:0]      step;
  logic [RW-1:0]   rem;
  logic [RW-1:0]   rem_sh;
  logic [RW-1:0]   diff;
  logic [TOT_W-1:0] dvs;
  logic            fits;

  // first step compares as is, later steps shift the partial remainder
  always_comb begin
    rem_sh = (step == 5'd0) ? rem : {rem[RW-2:0], 1'b0};
    diff   = rem_sh - {1'b0, dvs};
    fits   = rem_sh >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= RW'(dividend);
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff : rem_sh;
      quotient <= {quotient[SHARE_W-2:0], fits};
    end
  end

endmodule

@@ hdl/variance_share_decomposition.sv @@
// Variance share decomposition: squares each impulse-response coefficient into a
// saturating 48-bit accumulator per (variable, shock) pair and, at the end of each
// row, emits one Q1.15 share per shock. A coefficient that does not close a row is
// accumulated in S_UPD and the block returns to S_IDLE. After a row-closing one, the
// row total is gathered from the accumulator memory's single read port through
// S_SUM_RD and S_SUM_ACC per entry, and each share passes S_SH_RD, S_SH_GO, S_SH_WAIT
// (a bit-serial divider yielding one quotient bit per cycle, 16 bits) and S_OUT, where
// output stalls hold it. When the total does not exceed the minimum, each equal share
// skips S_SH_WAIT instead. One item is in work at a time. Restart clears the store at
// once through per-entry valid bits; no clearing pass is needed.
module variance_share_decomposition #(
  parameter int MAX_VARS    = vsd_pkg::DEF_MAX_VARS,
  parameter int MAX_HORIZON = vsd_pkg::DEF_MAX_HORIZON
) (
  input  logic       clk,
  input  logic       rst,
  vsd_cfg_if.sink    cfg,
  vsd_item_if.sink   items,
  vsd_result_if.source results
);
  import vsd_pkg::*;

  localparam int IW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int DEPTH = MAX_VARS * MAX_VARS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = ((IW > NV_W) ? IW : NV_W) + 1;
  localparam int HLIM  = (MAX_HORIZON - 1 > 255) ? 255 : MAX_HORIZON - 1;
  localparam logic [HOR_W-1:0] HOR_LIMIT = HOR_W'(HLIM);
  localparam logic [ACC_W-1:0] ACC_MAX   = '1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UPD     = 3'd1;
  localparam logic [2:0] S_SUM_RD  = 3'd2;
  localparam logic [2:0] S_SUM_ACC = 3'd3;
  localparam logic [2:0] S_SH_RD   = 3'd4;
  localparam logic [2:0] S_SH_GO   = 3'd5;
  localparam logic [2:0] S_SH_WAIT = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * MAX_VARS + int'(c));
  endfunction

  logic [2:0]         state;
  logic [NV_W-1:0]    num_vars;
  logic [ACC_W-1:0]   min_total;
  logic [IW-1:0]      row_count;
  logic [IW-1:0]      column_count;
  logic [HOR_W-1:0]   horizon_count;
  logic [IW-1:0]      shock;
  logic [SQ_W-1:0]    square;
  logic [TOT_W-1:0]   total;
  logic [SHARE_W-1:0] share;

  logic [NV_W-1:0]    n_act;
  logic [16:0]        mag;
  logic               item_xfer;
  logic               out_xfer;
  logic               row_end;
  logic               shock_last;
  logic               slice_end;
  logic               st_clr;
  logic               st_we;
  logic [AW-1:0]      st_raddr;
  logic [ACC_W-1:0]   st_rdata;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_new;
  logic               div_start;
  logic               div_done;
  logic [SHARE_W-1:0] div_q;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars  <= NV_W'(8);
      min_total <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_NUM_VARS:  num_vars  <= cfg.data[NV_W-1:0];
        REG_MIN_TOTAL: min_total <= cfg.data[ACC_W-1:0];
        default:       ;
      endcase
    end
  end

  // active variable count, clamped to 1..MAX_VARS
  always_comb begin
    if (num_vars == '0)                 n_act = NV_W'(1);
    else if (int'(num_vars) > MAX_VARS) n_act = NV_W'(MAX_VARS);
    else                                n_act = num_vars;
  end

  assign item_xfer  = items.valid && items.ready;
  assign out_xfer   = results.valid && results.ready;
  assign row_end    = (CW'(column_count) + CW'(1)) >= CW'(n_act);
  assign shock_last = (CW'(shock) + CW'(1)) >= CW'(n_act);
  assign slice_end  = (CW'(row_count) + CW'(1)) >= CW'(n_act);

  // coefficient magnitude
  assign mag = items.coefficient[COEF_W-1]
             ? 17'(-$signed({items.coefficient[COEF_W-1], items.coefficient}))
             : {1'b0, items.coefficient};

  // saturating accumulate
  assign acc_sum = {1'b0, st_rdata} + (ACC_W + 1)'(square);
  assign acc_new = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

  // store control
  assign st_clr = item_xfer && items.restart;
  assign st_we  = (state == S_UPD);
  always_comb begin
    if (state == S_IDLE) begin
      st_raddr = items.restart ? addr_of('0, '0) : addr_of(row_count, column_count);
    end else begin
      st_raddr = addr_of(row_count, shock);
    end
  end

  vsd_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .rst   (rst),
    .clr   (st_clr),
    .we    (st_we),
    .waddr (addr_of(row_count, column_count)),
    .wdata (acc_new),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign div_start = (state == S_SH_GO) && (total > TOT_W'(min_total));

  vsd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (st_rdata),
    .divisor  (total),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      row_count     <= '0;
      column_count  <= '0;
      horizon_count <= '0;
      shock         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_xfer) begin
            if (items.restart) begin
              row_count     <= '0;
              column_count  <= '0;
              horizon_count <= '0;
            end
            state <= S_UPD;
          end
        end
        S_UPD: begin
          shock <= '0;
          if (row_end) begin
            state <= S_SUM_RD;
          end else begin
            column_count <= column_count + IW'(1);
            state        <= S_IDLE;
          end
        end
        S_SUM_RD: state <= S_SUM_ACC;
        S_SUM_ACC: begin
          if (shock_last) begin
            shock <= '0;
            state <= S_SH_RD;
          end else begin
            shock <= shock + IW'(1);
            state <= S_SUM_RD;
          end
        end
        S_SH_RD: state <= S_SH_GO;
        S_SH_GO: state <= div_start ? S_SH_WAIT : S_OUT;
        S_SH_WAIT: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_xfer) begin
            if (shock_last) begin
              column_count <= '0;
              if (slice_end) begin
                row_count <= '0;
                if (horizon_count < HOR_LIMIT) horizon_count <= horizon_count + HOR_W'(1);
              end else begin
                row_count <= row_count + IW'(1);
              end
              state <= S_IDLE;
            end else begin
              shock <= shock + IW'(1);
              state <= S_SH_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (item_xfer) square <= SQ_W'(mag) * SQ_W'(mag);
    if (state == S_UPD) total <= '0;
    if (state == S_SUM_ACC) total <= total + TOT_W'(st_rdata);
    if (state == S_SH_GO && !div_start) share <= equal_share(n_act);
    if (state == S_SH_WAIT && div_done) share <= div_q;
  end

  // result channel
  assign items.ready            = (state == S_IDLE);
  assign results.valid          = (state == S_OUT);
  assign results.share          = share;
  assign results.variable_index = IDX_W'(row_count);
  assign results.shock_index    = IDX_W'(shock);
  assign results.horizon_index  = horizon_count;
  assign results.row_last       = shock_last;

  // checks
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    item_xfer |=> !items.ready)
    else $error("input ready while an item is in work");
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_SH_WAIT)
    else $error("divider finished outside its wait state");
  a_share_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.share <= ONE_Q15)
    else $error("share above one");
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    out_xfer && results.row_last |=> column_count == '0)
    else $error("column count not cleared after a row");

endmodule
